[rtl/gtg_pkg.sv]
// Shared types, constants and the arctangent table of the go-to-goal steering core.
package gtg_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int IW = $clog2(CORDIC_STEPS);

    localparam logic [1:0] ACT_GOAL = 2'd0;
    localparam logic [1:0] ACT_POSE = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic REG_MAX_SPEED = 1'b0;
    localparam logic REG_DEADBAND  = 1'b1;

    localparam logic [22:0] MAX_SPEED_RST = 23'd19661;
    localparam logic [14:0] DEADBAND_RST  = 15'd715;

    typedef enum logic [3:0] {
        OP_NONE, OP_START, OP_MUL, OP_SQRT_INIT, OP_SQRT, OP_CLOAD_BEAR, OP_CLOAD_YAW,
        OP_CNORM, OP_CQUAD, OP_CITER, OP_SAVE_BEAR, OP_SAVE_YAW, OP_ROUND, OP_FINISH
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_SQI, S_SQRT, S_BLOAD, S_BNORM, S_BQUAD, S_BITER, S_BSAVE,
        S_YLOAD, S_YNORM, S_YQUAD, S_YITER, S_YSAVE, S_ROUND, S_DONE
    } state_t;

    typedef struct packed {
        op_t  op;
        logic store_goal;
        logic store_pose;
    } gtg_cmd_t;

    typedef struct packed {
        logic goal_seen;
        logic pose_seen;
        logic mul_done;
        logic sqrt_done;
        logic norm_done;
        logic iter_done;
        logic out_free;
    } gtg_stat_t;

    function automatic logic signed [27:0] atan_q24(input logic [4:0] i);
        logic signed [27:0] r;
        case (i)
            5'd0:  r = 28'sd13176795;
            5'd1:  r = 28'sd7778716;
            5'd2:  r = 28'sd4110060;
            5'd3:  r = 28'sd2086331;
            5'd4:  r = 28'sd1047214;
            5'd5:  r = 28'sd524117;
            5'd6:  r = 28'sd262123;
            5'd7:  r = 28'sd131069;
            5'd8:  r = 28'sd65536;
            5'd9:  r = 28'sd32768;
            5'd10: r = 28'sd16384;
            5'd11: r = 28'sd8192;
            5'd12: r = 28'sd4096;
            5'd13: r = 28'sd2048;
            5'd14: r = 28'sd1024;
            5'd15: r = 28'sd512;
            5'd16: r = 28'sd256;
            5'd17: r = 28'sd128;
            5'd18: r = 28'sd64;
            5'd19: r = 28'sd32;
            5'd20: r = 28'sd16;
            5'd21: r = 28'sd8;
            5'd22: r = 28'sd4;
            5'd23: r = 28'sd2;
            default: r = 28'sd0;
        endcase
        return r;
    endfunction

endpackage

[rtl/gtg_if.sv]
// Request and drive command channel interfaces of the steering core.
interface gtg_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    modport source (output valid, action, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                    input ready);
    modport sink (input valid, action, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w,
                  output ready);
endinterface

interface gtg_drv_if;
    logic               valid;
    logic               ready;
    logic [22:0]        speed_cmd;
    logic signed [15:0] turn_cmd;

    modport source (output valid, speed_cmd, turn_cmd, input ready);
    modport sink (input valid, speed_cmd, turn_cmd, output ready);
endinterface

[rtl/gtg_ctrl.sv]
// Sequencing state machine of the steering core.
module gtg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [1:0]       req_action,
    input  gtg_pkg::gtg_stat_t stat,
    output logic             req_ready,
    output gtg_pkg::gtg_cmd_t  cmd
);
    import gtg_pkg::*;

    state_t state_reg, state_next;
    logic   tick_go;

    assign tick_go = req_valid && (req_action == ACT_TICK) && stat.goal_seen && stat.pose_seen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (tick_go) state_next = S_MUL;
            S_MUL:   if (stat.mul_done) state_next = S_SQI;
            S_SQI:   state_next = S_SQRT;
            S_SQRT:  if (stat.sqrt_done) state_next = S_BLOAD;
            S_BLOAD: state_next = S_BNORM;
            S_BNORM: if (stat.norm_done) state_next = S_BQUAD;
            S_BQUAD: state_next = S_BITER;
            S_BITER: if (stat.iter_done) state_next = S_BSAVE;
            S_BSAVE: state_next = S_YLOAD;
            S_YLOAD: state_next = S_YNORM;
            S_YNORM: if (stat.norm_done) state_next = S_YQUAD;
            S_YQUAD: state_next = S_YITER;
            S_YITER: if (stat.iter_done) state_next = S_YSAVE;
            S_YSAVE: state_next = S_ROUND;
            S_ROUND: state_next = S_DONE;
            S_DONE:  if (stat.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready      = 1'b0;
        cmd.op         = OP_NONE;
        cmd.store_goal = 1'b0;
        cmd.store_pose = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready      = 1'b1;
                cmd.store_goal = req_valid && (req_action == ACT_GOAL);
                cmd.store_pose = req_valid && (req_action == ACT_POSE);
                if (tick_go)
                    cmd.op = OP_START;
            end
            S_MUL:   cmd.op = OP_MUL;
            S_SQI:   cmd.op = OP_SQRT_INIT;
            S_SQRT:  cmd.op = OP_SQRT;
            S_BLOAD: cmd.op = OP_CLOAD_BEAR;
            S_YLOAD: cmd.op = OP_CLOAD_YAW;
            S_BNORM, S_YNORM: cmd.op = OP_CNORM;
            S_BQUAD, S_YQUAD: cmd.op = OP_CQUAD;
            S_BITER, S_YITER: cmd.op = OP_CITER;
            S_BSAVE: cmd.op = OP_SAVE_BEAR;
            S_YSAVE: cmd.op = OP_SAVE_YAW;
            S_ROUND: cmd.op = OP_ROUND;
            S_DONE:  if (stat.out_free) cmd.op = OP_FINISH;
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule

[rtl/gtg_dp.sv]
// Datapath of the steering core: stored poses, multiplier, square root, CORDIC, output.
module gtg_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  gtg_pkg::gtg_cmd_t  cmd,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    input  logic [22:0]        max_speed,
    input  logic [14:0]        heading_deadband,
    input  logic               out_ready,
    output gtg_pkg::gtg_stat_t stat,
    output logic               out_valid,
    output logic [22:0]        speed_cmd,
    output logic signed [15:0] turn_cmd
);
    import gtg_pkg::*;

    localparam logic [3:0] MUL_LAST = 4'd10;
    localparam logic signed [44:0] LIM40 = 45'sh100_0000_0000;
    localparam logic signed [44:0] LIM32 = 45'sh1_0000_0000;
    localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [18:0] PI_Q13 = 19'sd25736;
    localparam logic signed [18:0] TWO_PI_Q13 = 19'sd51472;

    logic signed [23:0] gx_reg, gy_reg, rx_reg, ry_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic               goal_seen_reg, pose_seen_reg;

    logic signed [24:0] dx_reg, dy_reg;
    logic [3:0]         mcnt_reg;
    logic signed [49:0] p_reg;
    logic [49:0]        ss_reg;
    logic signed [34:0] d_reg, g_reg, xq_reg, yq_reg;

    logic [49:0]        sv_reg, sr_reg;
    logic [4:0]         sk_reg;

    logic signed [44:0] cx_reg, cy_reg;
    logic signed [27:0] cz_reg, bear_reg, yaw_reg;
    logic               czero_reg;
    logic [IW-1:0]      ci_reg;

    logic [22:0]        spd_reg;
    logic signed [17:0] a_reg;
    logic               out_valid_reg;
    logic [22:0]        speed_out_reg;
    logic signed [15:0] turn_out_reg;

    logic signed [24:0] ma, mb;
    logic signed [49:0] prod;
    logic signed [34:0] p35, p2;
    logic [49:0]        sbit, strial;
    logic               sx40, sy40, sx32, sy32;
    logic signed [44:0] xs, ys;
    logic [34:0]        gabs;
    logic               yaw_zero;
    logic signed [28:0] ang;
    logic signed [18:0] wv, wt;
    logic [18:0]        wabs;

    always_comb
    begin
        case (mcnt_reg)
            4'd0:    begin ma = dx_reg; mb = dx_reg; end
            4'd1:    begin ma = dy_reg; mb = dy_reg; end
            4'd2:    begin ma = 25'(qx_reg); mb = 25'(qx_reg); end
            4'd3:    begin ma = 25'(qy_reg); mb = 25'(qy_reg); end
            4'd4:    begin ma = 25'(qz_reg); mb = 25'(qz_reg); end
            4'd5:    begin ma = 25'(qw_reg); mb = 25'(qw_reg); end
            4'd6:    begin ma = 25'(qx_reg); mb = 25'(qz_reg); end
            4'd7:    begin ma = 25'(qw_reg); mb = 25'(qy_reg); end
            4'd8:    begin ma = 25'(qx_reg); mb = 25'(qy_reg); end
            4'd9:    begin ma = 25'(qw_reg); mb = 25'(qz_reg); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    assign prod   = ma * mb;
    assign p35    = p_reg[34:0];
    assign p2     = {p35[33:0], 1'b0};
    assign sbit   = 50'd1 << {sk_reg, 1'b0};
    assign strial = sr_reg + sbit;
    assign sx40   = (cx_reg > -LIM40) && (cx_reg < LIM40);
    assign sy40   = (cy_reg > -LIM40) && (cy_reg < LIM40);
    assign sx32   = (cx_reg > -LIM32) && (cx_reg < LIM32);
    assign sy32   = (cy_reg > -LIM32) && (cy_reg < LIM32);
    assign xs     = cx_reg >>> ci_reg;
    assign ys     = cy_reg >>> ci_reg;
    assign gabs   = g_reg[34] ? $unsigned(-g_reg) : $unsigned(g_reg);
    assign yaw_zero = (d_reg == 35'sd0) || (gabs >= $unsigned(d_reg));
    assign ang    = {bear_reg[27], bear_reg} - {yaw_reg[27], yaw_reg} + 29'sd1024;

    always_comb
    begin
        wv = {a_reg[17], a_reg} + PI_Q13;
        if (wv < 19'sd0)
            wv = wv + TWO_PI_Q13;
        else if (wv >= TWO_PI_Q13)
            wv = wv - TWO_PI_Q13;
        wt = wv - PI_Q13;
        wabs = wt[18] ? $unsigned(-wt) : $unsigned(wt);
        if (wabs < {4'd0, heading_deadband})
            wt = 19'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_seen_reg <= 1'b0;
            pose_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.store_goal)
                goal_seen_reg <= 1'b1;
            if (cmd.store_pose)
                pose_seen_reg <= 1'b1;
            if (cmd.op == OP_FINISH)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_goal)
        begin
            gx_reg <= pos_x;
            gy_reg <= pos_y;
        end
        if (cmd.store_pose)
        begin
            rx_reg <= pos_x;
            ry_reg <= pos_y;
            qx_reg <= quat_x;
            qy_reg <= quat_y;
            qz_reg <= quat_z;
            qw_reg <= quat_w;
        end

        case (cmd.op)
            OP_START:
            begin
                dx_reg   <= 25'(gx_reg) - 25'(rx_reg);
                dy_reg   <= 25'(gy_reg) - 25'(ry_reg);
                mcnt_reg <= '0;
                ss_reg   <= '0;
                d_reg    <= '0;
                g_reg    <= '0;
                xq_reg   <= '0;
                yq_reg   <= '0;
            end
            OP_MUL:
            begin
                p_reg    <= prod;
                mcnt_reg <= mcnt_reg + 4'd1;
                case (4'(mcnt_reg - 4'd1))
                    4'd0, 4'd1: ss_reg <= ss_reg + $unsigned(p_reg);
                    4'd2, 4'd5:
                    begin
                        d_reg  <= d_reg + p35;
                        xq_reg <= xq_reg + p35;
                    end
                    4'd3, 4'd4:
                    begin
                        d_reg  <= d_reg + p35;
                        xq_reg <= xq_reg - p35;
                    end
                    4'd6:       g_reg  <= g_reg + p2;
                    4'd7:       g_reg  <= g_reg - p2;
                    4'd8, 4'd9: yq_reg <= yq_reg + p2;
                    default:    ;
                endcase
            end
            OP_SQRT_INIT:
            begin
                sv_reg <= ss_reg;
                sr_reg <= '0;
                sk_reg <= 5'd24;
            end
            OP_SQRT:
            begin
                if (sv_reg >= strial)
                begin
                    sv_reg <= sv_reg - strial;
                    sr_reg <= (sr_reg >> 1) + sbit;
                end
                else
                    sr_reg <= sr_reg >> 1;
                sk_reg <= sk_reg - 5'd1;
            end
            OP_CLOAD_BEAR:
            begin
                cx_reg    <= 45'(dx_reg);
                cy_reg    <= 45'(dy_reg);
                czero_reg <= (dx_reg == 25'sd0) && (dy_reg == 25'sd0);
            end
            OP_CLOAD_YAW:
            begin
                cx_reg    <= 45'(xq_reg);
                cy_reg    <= 45'(yq_reg);
                czero_reg <= yaw_zero || ((xq_reg == 35'sd0) && (yq_reg == 35'sd0));
            end
            OP_CNORM:
            begin
                if (!czero_reg && sx40 && sy40)
                begin
                    if (sx32 && sy32)
                    begin
                        cx_reg <= cx_reg <<< 8;
                        cy_reg <= cy_reg <<< 8;
                    end
                    else
                    begin
                        cx_reg <= cx_reg <<< 1;
                        cy_reg <= cy_reg <<< 1;
                    end
                end
            end
            OP_CQUAD:
            begin
                ci_reg <= '0;
                if (cx_reg < 45'sd0)
                begin
                    if (cy_reg >= 45'sd0)
                    begin
                        cx_reg <= cy_reg;
                        cy_reg <= -cx_reg;
                        cz_reg <= HALF_PI_Q24;
                    end
                    else
                    begin
                        cx_reg <= -cy_reg;
                        cy_reg <= cx_reg;
                        cz_reg <= -HALF_PI_Q24;
                    end
                end
                else
                    cz_reg <= '0;
            end
            OP_CITER:
            begin
                ci_reg <= ci_reg + 1'b1;
                if (cy_reg > 45'sd0)
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan_q24(5'(ci_reg));
                end
                else
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan_q24(5'(ci_reg));
                end
            end
            OP_SAVE_BEAR: bear_reg <= czero_reg ? 28'sd0 : cz_reg;
            OP_SAVE_YAW:  yaw_reg  <= czero_reg ? 28'sd0 : cz_reg;
            OP_ROUND:
            begin
                a_reg   <= ang[28:11];
                spd_reg <= (sr_reg[24:0] > {2'b00, max_speed}) ? max_speed : sr_reg[22:0];
            end
            OP_FINISH:
            begin
                speed_out_reg <= spd_reg;
                turn_out_reg  <= wt[15:0];
            end
            default: ;
        endcase
    end

    assign stat.goal_seen = goal_seen_reg;
    assign stat.pose_seen = pose_seen_reg;
    assign stat.mul_done  = (mcnt_reg == MUL_LAST);
    assign stat.sqrt_done = (sk_reg == 5'd0);
    assign stat.norm_done = czero_reg || !(sx40 && sy40);
    assign stat.iter_done = (ci_reg == IW'(CORDIC_STEPS - 1));
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign speed_cmd = speed_out_reg;
    assign turn_cmd  = turn_out_reg;

endmodule

[rtl/go_to_goal_steering_core.sv]
// Top level of the go-to-goal steering core: register port, controller and datapath.
//
//  channel  role    handshake          carries
//  req      sink    valid / ready      action, pos_x, pos_y, quat_x..quat_w
//  drv      source  valid / ready      speed_cmd, turn_cmd
//  apb      slave   psel / penable     max_speed at 0x0, heading_deadband at 0x4
//
// A tick runs the shared multiplier pass, the one-bit-per-cycle square root and two CORDIC
// runs, each CORDIC run after its own normalization phase.
// Reset is asynchronous and active low; the block holds one request at a time,
// and a finished command waits in the output register while the next request is taken.
module go_to_goal_steering_core (
    input  logic        clk,
    input  logic        rst_n,
    gtg_req_if.sink     req,
    gtg_drv_if.source   drv,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gtg_pkg::*;

    logic [22:0] max_speed_reg;
    logic [14:0] deadband_reg;
    gtg_cmd_t    cmd;
    gtg_stat_t   stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= MAX_SPEED_RST;
            deadband_reg  <= DEADBAND_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_MAX_SPEED: max_speed_reg <= pwdata[22:0];
                REG_DEADBAND:  deadband_reg  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MAX_SPEED: prdata = {9'd0, max_speed_reg};
            REG_DEADBAND:  prdata = {17'd0, deadband_reg};
            default:       prdata = '0;
        endcase
    end

    gtg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_action (req.action),
        .stat       (stat),
        .req_ready  (req.ready),
        .cmd        (cmd)
    );

    gtg_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .pos_x            (req.pos_x),
        .pos_y            (req.pos_y),
        .quat_x           (req.quat_x),
        .quat_y           (req.quat_y),
        .quat_z           (req.quat_z),
        .quat_w           (req.quat_w),
        .max_speed        (max_speed_reg),
        .heading_deadband (deadband_reg),
        .out_ready        (drv.ready),
        .stat             (stat),
        .out_valid        (drv.valid),
        .speed_cmd        (drv.speed_cmd),
        .turn_cmd         (drv.turn_cmd)
    );

endmodule

[rtl/gtg_checker.sv]
// Port-level assertions of the steering core and their bind.
module gtg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               drv_valid,
    input logic               drv_ready,
    input logic [22:0]        speed_cmd,
    input logic signed [15:0] turn_cmd,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [2:0]         paddr,
    input logic [31:0]        pwdata
);
    import gtg_pkg::*;

    logic [22:0] max_shadow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_shadow_reg <= MAX_SPEED_RST;
        else if (psel && penable && pwrite && (paddr[2] == REG_MAX_SPEED))
            max_shadow_reg <= pwdata[22:0];
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        drv_valid && !drv_ready |=> drv_valid)
        else $error("drive command dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        drv_valid && !drv_ready |=> $stable(speed_cmd) && $stable(turn_cmd))
        else $error("drive command changed while stalled");

    a_turn: assert property (@(posedge clk) disable iff (!rst_n)
        drv_valid |-> (turn_cmd >= -16'sd25736) && (turn_cmd <= 16'sd25735))
        else $error("turn command outside the wrapped range");

    a_speed: assert property (@(posedge clk) disable iff (!rst_n)
        drv_valid |-> speed_cmd <= max_shadow_reg)
        else $error("speed command above the configured cap");

endmodule

bind go_to_goal_steering_core gtg_checker u_gtg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .drv_valid (drv.valid),
    .drv_ready (drv.ready),
    .speed_cmd (drv.speed_cmd),
    .turn_cmd  (drv.turn_cmd),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata)
);

[tb/go_to_goal_steering_core_tb.sv]
// Self-checking testbench of the go-to-goal steering core with a bit-true command predictor.
`timescale 1ns / 100ps

module go_to_goal_steering_core_tb;
    import gtg_pkg::*;

    typedef struct packed {
        logic [22:0]        speed;
        logic signed [15:0] turn;
    } drive_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    gtg_req_if req ();
    gtg_drv_if drv ();

    go_to_goal_steering_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req.sink),
        .drv     (drv.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    drive_cmd_t  cmd_queue[$];
    int          mismatches;
    int          out_wait;
    int          out_draw;
    logic [22:0] cap_speed;
    logic [14:0] deadband;
    logic signed [23:0] goal_x, goal_y, robot_x, robot_y;
    logic signed [15:0] rq[4];
    bit          have_goal, have_pose;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    function automatic longint sra(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint labs(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint angle_of(input longint x0, input longint y0);
        longint x, y, z, t, xs, ys;
        longint tbl[24];
        x = x0;
        y = y0;
        z = 0;
        tbl = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
                65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                256, 128, 64, 32, 16, 8, 4, 2};
        if (x == 0 && y == 0)
            return 0;
        while (labs(x) < (64'sd1 <<< 40) && labs(y) < (64'sd1 <<< 40))
        begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 26353589;
            end
            else
            begin
                x = -y; y = t; z = -26353589;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            xs = sra(x, i);
            ys = sra(y, i);
            if (y > 0)
            begin
                x += ys; y -= xs; z += tbl[i];
            end
            else
            begin
                x -= ys; y += xs; z -= tbl[i];
            end
        end
        return z;
    endfunction

    function automatic longint robot_yaw();
        longint qx, qy, qz, qw, d, g;
        qx = rq[0]; qy = rq[1]; qz = rq[2]; qw = rq[3];
        d = qx * qx + qy * qy + qz * qz + qw * qw;
        g = 2 * (qx * qz - qw * qy);
        if (d == 0 || labs(g) >= d)
            return 0;
        return angle_of(qw * qw + qx * qx - qy * qy - qz * qz, 2 * (qx * qy + qw * qz));
    endfunction

    function automatic longint floor_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    task automatic predict_drive(input logic [1:0] act, input logic signed [23:0] px,
                                 input logic signed [23:0] py, input logic signed [15:0] q0,
                                 input logic signed [15:0] q1, input logic signed [15:0] q2,
                                 input logic signed [15:0] q3);
        longint dx, dy, ang, a;
        longint unsigned span;
        drive_cmd_t c;
        if (act == ACT_GOAL)
        begin
            goal_x = px; goal_y = py; have_goal = 1;
        end
        else if (act == ACT_POSE)
        begin
            robot_x = px; robot_y = py; have_pose = 1;
            rq[0] = q0; rq[1] = q1; rq[2] = q2; rq[3] = q3;
        end
        else if (act == ACT_TICK && have_goal && have_pose)
        begin
            dx = longint'(goal_x) - longint'(robot_x);
            dy = longint'(goal_y) - longint'(robot_y);
            span = floor_sqrt(dx * dx + dy * dy);
            if (span > cap_speed)
                span = cap_speed;
            ang = angle_of(dx, dy) - robot_yaw();
            a = sra(ang + (64'sd1 <<< 10), 11);
            a = (a + 25736) % 51472;
            if (a < 0)
                a += 51472;
            a -= 25736;
            if (labs(a) < deadband)
                a = 0;
            c.speed = span[22:0];
            c.turn = a[15:0];
            cmd_queue.push_back(c);
        end
    endtask

    task automatic send_request(input logic [1:0] act, input logic signed [23:0] px,
                                input logic signed [23:0] py, input logic signed [15:0] q0,
                                input logic signed [15:0] q1, input logic signed [15:0] q2,
                                input logic signed [15:0] q3);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid  <= 1'b1;
        req.action <= act;
        req.pos_x  <= px;
        req.pos_y  <= py;
        req.quat_x <= q0;
        req.quat_y <= q1;
        req.quat_z <= q2;
        req.quat_w <= q3;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_drive(act, px, py, q0, q1, q2, q3);
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (cmd_queue.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MAX_SPEED)
            cap_speed = val[22:0];
        else
            deadband = val[14:0];
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            drv.ready <= 1'b0;
            out_wait  <= 0;
        end
        else
        begin
            if (drv.valid && drv.ready)
            begin
                if (cmd_queue.size() == 0)
                    report("unexpected command", drv.speed_cmd, 0);
                else
                begin
                    if (drv.speed_cmd !== cmd_queue[0].speed)
                        report("speed_cmd", drv.speed_cmd, cmd_queue[0].speed);
                    if (drv.turn_cmd !== cmd_queue[0].turn)
                        report("turn_cmd", drv.turn_cmd, cmd_queue[0].turn);
                    void'(cmd_queue.pop_front());
                end
                out_draw = $urandom_range(0, 3);
                out_wait  <= out_draw;
                drv.ready <= (out_draw == 0);
            end
            else if (!drv.ready)
            begin
                if (out_wait <= 1)
                    drv.ready <= 1'b1;
                out_wait <= out_wait - 1;
            end
        end
    end

    function automatic logic signed [23:0] rand_pos();
        case ($urandom_range(0, 4))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            2: return 24'($urandom_range(0, 400000) - 200000);
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic signed [15:0] rand_quat();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return -16'sh8000;
            2: return 16'sd0;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic test_before_any_state();
        send_request(ACT_TICK, 0, 0, 0, 0, 0, 0);
        send_request(ACT_GOAL, 100, 200, 16'sh7FFF, 0, 0, 0);
        send_request(ACT_TICK, 0, 0, 0, 0, 0, 0);
        send_request(2'd3, 1, 1, 1, 1, 1, 1);
    endtask

    task automatic test_directed();
        send_request(ACT_POSE, 100, 200, 0, 0, 0, 0);
        send_request(ACT_TICK, 0, 0, 0, 0, 0, 0);
        send_request(ACT_POSE, 0, 0, 0, 0, 0, 16'sh7FFF);
        send_request(ACT_TICK, 0, 0, 0, 0, 0, 0);
        send_request(ACT_GOAL, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0, 0, 0);
        send_request(ACT_POSE, -24'sh800000, -24'sh800000, 0, 0, 16'sh5A82, 16'sh5A82);
        send_request(ACT_TICK, 0, 0, 0, 0, 0, 0);
        send_request(ACT_POSE, 5, 5, 16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000);
        send_request(ACT_TICK, 0, 0, 0, 0, 0, 0);
        send_request(ACT_GOAL, -24'sh800000, 0, 0, 0, 0, 0);
        send_request(ACT_POSE, 24'sh7FFFFF, 1, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
        send_request(ACT_TICK, 0, 0, 0, 0, 0, 0);
        send_request(ACT_POSE, 0, -1, 16'sh1234, -16'sh4321, 16'sh7FFF, -16'sh0100);
        send_request(2'd3, 0, 0, 0, 0, 0, 0);
        send_request(ACT_TICK, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_config_extremes();
        write_reg(REG_MAX_SPEED, 32'h7FFFFF);
        write_reg(REG_DEADBAND, 32'd0);
        send_request(ACT_TICK, 0, 0, 0, 0, 0, 0);
        write_reg(REG_MAX_SPEED, 32'd0);
        write_reg(REG_DEADBAND, 32'd25735);
        send_request(ACT_TICK, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random(input int count);
        logic [1:0] act;
        for (int n = 0; n < count; n++)
        begin
            if (n % 250 == 0)
            begin
                write_reg(REG_MAX_SPEED, (n % 500 == 0) ? $urandom() : $urandom_range(0, 60000));
                write_reg(REG_DEADBAND, $urandom_range(0, 25735));
            end
            case ($urandom_range(0, 9))
                0, 1, 2: act = ACT_GOAL;
                3, 4, 5: act = ACT_POSE;
                9: act = 2'd3;
                default: act = ACT_TICK;
            endcase
            send_request(act, rand_pos(), rand_pos(), rand_quat(), rand_quat(),
                         rand_quat(), rand_quat());
            if (act != ACT_GOAL && act != ACT_POSE && act != ACT_TICK)
                n--;
            if (n == count / 2)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        req.valid = 0; req.action = 0; req.pos_x = 0; req.pos_y = 0;
        req.quat_x = 0; req.quat_y = 0; req.quat_z = 0; req.quat_w = 0;
        cap_speed = MAX_SPEED_RST;
        deadband = DEADBAND_RST;
        goal_x = 0; goal_y = 0; robot_x = 0; robot_y = 0;
        rq = '{0, 0, 0, 0};
        have_goal = 0; have_pose = 0;
        mismatches = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_any_state();
        test_directed();
        test_config_extremes();
        test_random(1000);
        wait_drained();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
